// File: rtl/mlbt_pkg.sv
package mlbt_pkg;

  localparam int MacWidth = 48;

  typedef logic [MacWidth-1:0] mac_t;

  typedef struct packed {
    mac_t mac;
    logic port;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic en;
    logic entry_valid;
  } cmp_ctrl_t;

  typedef struct packed {
    logic dest_hit;
    logic dest_port;
    logic src_hit;
  } cmp_status_t;

endpackage

// File: rtl/mlbt_mem.sv
module mlbt_mem #(
  parameter int DEPTH = 128,
  parameter int AW = 7
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  mlbt_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output mlbt_pkg::entry_t rdata
);
  import mlbt_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/mlbt_cmp.sv
module mlbt_cmp (
  input  logic                 clk,
  input  mlbt_pkg::cmp_ctrl_t  ctrl,
  input  mlbt_pkg::mac_t       dest_mac,
  input  mlbt_pkg::mac_t       src_mac,
  input  mlbt_pkg::entry_t     entry,
  output mlbt_pkg::cmp_status_t status
);
  import mlbt_pkg::*;

  logic dest_eq;
  logic src_eq;

  assign dest_eq = ctrl.en && ctrl.entry_valid && (entry.mac == dest_mac);
  assign src_eq  = ctrl.en && ctrl.entry_valid && (entry.mac == src_mac);

  // first hit in index order wins for the destination
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      status <= '0;
    end else begin
      if (dest_eq && !status.dest_hit) begin
        status.dest_hit  <= 1'b1;
        status.dest_port <= entry.port;
      end
      if (src_eq) begin
        status.src_hit <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/mac_learning_bridge_table.sv
// done strobes once the SCAN, DRAIN and FINISH states have run after start is taken
// no new transaction is taken while busy; busy lasts through the scan of one
// table entry per cycle through the single memory read port and compare unit
// reset: rst clears the fill count, write pointer and sequencer; table contents stay
// the receiver cannot stall, each result is shown on done for one cycle
module mac_learning_bridge_table #(
  parameter int TABLE_ENTRIES = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  mlbt_pkg::mac_t       dest_mac,
  input  mlbt_pkg::mac_t       src_mac,
  input  logic                 ingress_port,
  output logic                 done,
  output logic                 send_port0,
  output logic                 send_port1,
  output logic                 dest_known,
  output logic                 found_port,
  output logic                 learned
);
  import mlbt_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int FW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IW-1:0] LastIdx = IW'(TABLE_ENTRIES - 1);
  localparam logic [FW-1:0] FullCnt = FW'(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DRAIN,
    FINISH
  } state_t;

  state_t      state;
  mac_t        dmac;
  mac_t        smac;
  logic        ing;
  logic [IW-1:0] idx;
  logic [IW-1:0] cmp_idx;
  logic        cmp_en;
  logic [IW-1:0] write_pointer;
  logic [FW-1:0] fill;
  logic        clear;

  entry_t      rdata;
  entry_t      wdata;
  logic        we;
  cmp_ctrl_t   ctrl;
  cmp_status_t status;

  assign busy  = (state != IDLE);
  assign we    = (state == FINISH) && !status.src_hit;
  assign wdata = '{mac: smac, port: ing};

  assign ctrl.clear       = clear;
  assign ctrl.en          = cmp_en;
  assign ctrl.entry_valid = (FW'(cmp_idx) < fill);

  mlbt_mem #(
    .DEPTH(TABLE_ENTRIES),
    .AW(IW)
  ) u_mem (
    .clk(clk),
    .we(we),
    .waddr(write_pointer),
    .wdata(wdata),
    .re(state == SCAN),
    .raddr(idx),
    .rdata(rdata)
  );

  mlbt_cmp u_cmp (
    .clk(clk),
    .ctrl(ctrl),
    .dest_mac(dmac),
    .src_mac(smac),
    .entry(rdata),
    .status(status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      idx           <= '0;
      cmp_idx       <= '0;
      cmp_en        <= 1'b0;
      clear         <= 1'b0;
      write_pointer <= '0;
      fill          <= '0;
      done          <= 1'b0;
    end else begin
      done    <= 1'b0;
      clear   <= 1'b0;
      cmp_en  <= (state == SCAN);
      cmp_idx <= idx;
      case (state)
        IDLE: begin
          if (start) begin
            dmac  <= dest_mac;
            smac  <= src_mac;
            ing   <= ingress_port;
            idx   <= '0;
            clear <= 1'b1;
            state <= SCAN;
          end
        end
        SCAN: begin
          if (idx == LastIdx) begin
            state <= DRAIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        DRAIN: begin
          state <= FINISH;
        end
        FINISH: begin
          done       <= 1'b1;
          dest_known <= status.dest_hit;
          found_port <= status.dest_hit && status.dest_port;
          send_port0 <= !status.dest_hit || !status.dest_port;
          send_port1 <= !status.dest_hit || status.dest_port;
          learned    <= !status.src_hit;
          if (!status.src_hit) begin
            write_pointer <= (write_pointer == LastIdx) ? '0 : write_pointer + 1'b1;
            if (fill != FullCnt) begin
              fill <= fill + 1'b1;
            end
          end
          state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FullCnt)
    else $error("fill count above table size");

  a_ptr_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    (fill != FullCnt) |-> (FW'(write_pointer) == fill))
    else $error("write pointer out of step with fill count");

  a_done_nonempty: assert property (@(posedge clk) disable iff (rst)
    done |-> (fill != '0))
    else $error("result given with empty table");

  a_known_one_port: assert property (@(posedge clk) disable iff (rst)
    (done && dest_known) |-> (send_port0 != send_port1))
    else $error("known destination sent to both ports");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("sequencer did not take transaction");
`endif

endmodule

// File: verif/mac_learning_bridge_table_checker.sv
module mac_learning_bridge_table_checker #(
  parameter int TABLE_ENTRIES = 128
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  mlbt_pkg::mac_t dest_mac,
  input  mlbt_pkg::mac_t src_mac,
  input  logic           ingress_port,
  input  logic           done,
  input  logic           send_port0,
  input  logic           send_port1,
  input  logic           dest_known,
  input  logic           found_port,
  input  logic           learned,
  output int             errors,
  output int             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import mlbt_pkg::*;

  typedef struct packed {
    logic to_port0;
    logic to_port1;
    logic dest_hit;
    logic dest_port;
    logic src_new;
  } fwd_t;

  mac_t        station_mac   [TABLE_ENTRIES];
  logic        station_port  [TABLE_ENTRIES];
  logic        station_valid [TABLE_ENTRIES];
  int unsigned fill_slot;
  fwd_t        expected_fwd[$];
  int          fail_count = 0;

  assign errors  = fail_count;
  assign pending = expected_fwd.size();

  // forwarding decision on the table as it stands, then source learning
  function automatic fwd_t forward_and_learn(mac_t dmac, mac_t smac, logic inport);
    fwd_t f;
    int   dest_idx;
    int   src_idx;
    dest_idx = -1;
    src_idx  = -1;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (station_valid[k] && station_mac[k] == dmac && dest_idx < 0) dest_idx = k;
      if (station_valid[k] && station_mac[k] == smac && src_idx < 0) src_idx = k;
    end
    if (dest_idx >= 0) begin
      f.dest_hit  = 1'b1;
      f.dest_port = station_port[dest_idx];
      f.to_port0  = !station_port[dest_idx];
      f.to_port1  = station_port[dest_idx];
    end else begin
      f.dest_hit  = 1'b0;
      f.dest_port = 1'b0;
      f.to_port0  = 1'b1;
      f.to_port1  = 1'b1;
    end
    f.src_new = (src_idx < 0);
    if (src_idx < 0) begin
      station_mac[fill_slot]   = smac;
      station_port[fill_slot]  = inport;
      station_valid[fill_slot] = 1'b1;
      fill_slot = (fill_slot + 1) % TABLE_ENTRIES;
    end
    return f;
  endfunction

  task automatic check_field(string fld, logic want_bit, logic got_bit);
    if (got_bit !== want_bit) begin
      $display("%0t: %s expected %b got %b", $time, fld, want_bit, got_bit);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    fwd_t want;
    if (rst) begin
      for (int k = 0; k < TABLE_ENTRIES; k++) station_valid[k] = 1'b0;
      fill_slot = 0;
      expected_fwd.delete();
    end else begin
      if (done) begin
        if (expected_fwd.size() == 0) begin
          $display("%0t: result with no transaction outstanding", $time);
          fail_count++;
        end else begin
          want = expected_fwd.pop_front();
          check_field("send_port0", want.to_port0, send_port0);
          check_field("send_port1", want.to_port1, send_port1);
          check_field("dest_known", want.dest_hit, dest_known);
          check_field("found_port", want.dest_port, found_port);
          check_field("learned", want.src_new, learned);
        end
      end
      if (start && !busy) begin
        expected_fwd.push_back(forward_and_learn(dest_mac, src_mac, ingress_port));
      end
    end
  end

endmodule

// File: verif/mac_learning_bridge_table_test.sv
module mac_learning_bridge_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mlbt_pkg::*;

  localparam int TableEntries = 128;
  localparam int NumFrames    = 1800;
  localparam int NumStations  = 160;
  localparam int CycleLimit   = 3_000_000;

  logic clk          = 1'b0;
  logic rst          = 1'b1;
  logic start        = 1'b0;
  mac_t dest_mac     = '0;
  mac_t src_mac      = '0;
  logic ingress_port = 1'b0;
  logic busy;
  logic done;
  logic send_port0;
  logic send_port1;
  logic dest_known;
  logic found_port;
  logic learned;
  int   errors;
  int   pending;
  int   cycles = 0;

  mac_t stations[NumStations];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mac_learning_bridge_table #(
    .TABLE_ENTRIES(TableEntries)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .dest_mac    (dest_mac),
    .src_mac     (src_mac),
    .ingress_port(ingress_port),
    .done        (done),
    .send_port0  (send_port0),
    .send_port1  (send_port1),
    .dest_known  (dest_known),
    .found_port  (found_port),
    .learned     (learned)
  );

  mac_learning_bridge_table_checker #(
    .TABLE_ENTRIES(TableEntries)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .dest_mac    (dest_mac),
    .src_mac     (src_mac),
    .ingress_port(ingress_port),
    .done        (done),
    .send_port0  (send_port0),
    .send_port1  (send_port1),
    .dest_known  (dest_known),
    .found_port  (found_port),
    .learned     (learned),
    .errors      (errors),
    .pending     (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("mac_learning_bridge_table_test: errors");
      $finish;
    end
  end

  function automatic mac_t random_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic send_frame(mac_t dmac, mac_t smac, logic inport);
    start        <= 1'b1;
    dest_mac     <= dmac;
    src_mac      <= smac;
    ingress_port <= inport;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // n must be at least one; junk on the frame fields must be ignored
  task automatic rest(int n);
    start        <= 1'b0;
    dest_mac     <= random_mac();
    src_mac      <= random_mac();
    ingress_port <= 1'($urandom);
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin : stimulus
    int   idle_pct [4] = '{0, 67, 0, 14};
    int   phase;
    int   sel;
    mac_t dmac;
    mac_t smac;

    for (int k = 0; k < NumStations; k++) stations[k] = random_mac();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // unknown destination equal to source: flood, then learn
    send_frame(48'h0000_0000_0000, 48'h0000_0000_0000, 1'b0);
    send_frame(48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF, 1'b1);
    send_frame(48'hFFFF_FFFF_FFFF, 48'h0000_0000_0000, 1'b0);
    // known source on the other port keeps its stored port
    send_frame(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
    // sent back out of the ingress port
    send_frame(48'h0000_0000_0000, 48'h0000_0000_0000, 1'b0);
    send_frame(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
    // multicast stays flooded until learned
    send_frame(48'h0100_5E00_0001, 48'hAAAA_AAAA_AAAA, 1'b1);
    send_frame(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 1'b0);
    send_frame(48'h5555_5555_5555, 48'h0100_5E00_0001, 1'b1);
    send_frame(48'h0100_5E00_0001, 48'h0000_0000_0001, 1'b0);
    send_frame(48'h8000_0000_0000, 48'h8000_0000_0000, 1'b1);
    send_frame(48'h8000_0000_0000, 48'h0000_0000_0001, 1'b1);
    send_frame(48'h0000_0000_0001, 48'h8000_0000_0000, 1'b0);
    drain();

    for (int i = 0; i < NumFrames; i++) begin
      phase = i * 4 / NumFrames;
      if (i > 0 && phase != (i - 1) * 4 / NumFrames) drain();
      if ($urandom_range(99) < idle_pct[phase]) rest($urandom_range(1, 160));
      sel = $urandom_range(99);
      if (sel < 70) dmac = stations[$urandom_range(NumStations - 1)];
      else if (sel < 85) dmac = random_mac();
      else if (sel < 91) dmac = 48'hFFFF_FFFF_FFFF;
      else dmac = random_mac() | 48'h0100_0000_0000;
      if ($urandom_range(99) < 85) smac = stations[$urandom_range(NumStations - 1)];
      else smac = random_mac();
      if ($urandom_range(99) < 4) dmac = smac;
      send_frame(dmac, smac, 1'($urandom));
    end

    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (TableEntries + 8) @(posedge clk);
    if (errors == 0) begin
      $display("mac_learning_bridge_table_test: clean");
    end else begin
      $display("mac_learning_bridge_table_test: errors");
    end
    $finish;
  end

endmodule
